[rtl/waypoint_follow_controller_assert.svh]
// ----------------------------------------------------------------------------
// waypoint follow controller assertion macros
// concurrent checks sampled on clk, switched off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOW_CONTROLLER_ASSERT_SVH
`define WAYPOINT_FOLLOW_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// property holds at every edge
`define WFC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wfc check failed");

// consequent holds in the same cycle
`define WFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfc check failed");

// consequent holds in the next cycle
`define WFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfc check failed");

`else

`define WFC_ASSERT_ALWAYS(label, expr)
`define WFC_ASSERT_IMPL(label, ante, cons)
`define WFC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/wfc_pkg.sv]
// ----------------------------------------------------------------------------
// wfc_pkg
// shared item types, codes and fixed constants of the waypoint follower
// ----------------------------------------------------------------------------
package wfc_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] heading;
    logic               first_point;
    logic               blocked;
    logic [2:0]         command;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        linear_speed;
    logic signed [15:0] angular_speed;
    logic [2:0]         phase;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  index;
    logic [22:0] data;
  } cfg_wr_t;

  // item kinds
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_CMD  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // commands
  localparam logic [2:0] CMD_PAUSE  = 3'd0;
  localparam logic [2:0] CMD_RESUME = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_MANUAL = 3'd3;
  localparam logic [2:0] CMD_AUTO   = 3'd4;

  // phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DRIVE  = 3'd1;
  localparam logic [2:0] PH_ROTATE = 3'd2;
  localparam logic [2:0] PH_ALIGN  = 3'd3;
  localparam logic [2:0] PH_DWELL  = 3'd4;
  localparam logic [2:0] PH_SPIN   = 3'd5;
  localparam logic [2:0] PH_CREEP  = 3'd6;

  // register indexes
  localparam logic [2:0] CFG_CRUISE     = 3'd0;
  localparam logic [2:0] CFG_TURN       = 3'd1;
  localparam logic [2:0] CFG_SLOW       = 3'd2;
  localparam logic [2:0] CFG_SLOW_RAD   = 3'd3;
  localparam logic [2:0] CFG_ARRIVE_RAD = 3'd4;
  localparam logic [2:0] CFG_ALIGN_TOL  = 3'd5;
  localparam logic [2:0] CFG_ALIGN_TRIG = 3'd6;
  localparam logic [2:0] CFG_DWELL      = 3'd7;

  localparam logic [14:0] RST_CRUISE     = 15'd1024;
  localparam logic [14:0] RST_TURN       = 15'd2048;
  localparam logic [14:0] RST_SLOW       = 15'd410;
  localparam logic [22:0] RST_SLOW_RAD   = 23'd9830;
  localparam logic [22:0] RST_ARRIVE_RAD = 23'd3277;
  localparam logic [14:0] RST_ALIGN_TOL  = 15'd1638;
  localparam logic [14:0] RST_ALIGN_TRIG = 15'd4096;
  localparam logic [15:0] RST_DWELL      = 16'd100;

  // angle word, radians times 8192
  localparam int ANGW = 20;
  localparam logic signed [ANGW-1:0] ANG_PI      = 20'sd25736;
  localparam logic signed [ANGW-1:0] ANG_2PI     = 20'sd51472;
  localparam logic signed [ANGW-1:0] ANG_HALF_PI = 20'sd12868;
  localparam logic signed [ANGW-1:0] NEAR_BIAS   = 20'sd82;
  localparam logic signed [28:0]     PI_Q24      = 29'sd52707179;

  // ceil(2^20 / 20), exact for the steering quotient over 16-bit operands
  localparam logic [24:0] STEER_RECIP = 25'd52429;

  // request queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  function automatic logic signed [ANGW-1:0] wrap_angle(input logic signed [ANGW-1:0] b);
    logic signed [ANGW-1:0] r;
    r = b;
    if (b > ANG_PI) begin
      r = b - ANG_2PI;
    end else if (b <= -ANG_PI) begin
      r = b + ANG_2PI;
    end
    return r;
  endfunction

  // atan(2^-i), radians times 2^24
  function automatic logic [26:0] atan_q24(input logic [4:0] i);
    logic [26:0] r;
    unique case (i)
      5'd0:  r = 27'd13176795;
      5'd1:  r = 27'd7778716;
      5'd2:  r = 27'd4110060;
      5'd3:  r = 27'd2086331;
      5'd4:  r = 27'd1047214;
      5'd5:  r = 27'd524117;
      5'd6:  r = 27'd262123;
      5'd7:  r = 27'd131069;
      5'd8:  r = 27'd65536;
      5'd9:  r = 27'd32768;
      5'd10: r = 27'd16384;
      5'd11: r = 27'd8192;
      5'd12: r = 27'd4096;
      5'd13: r = 27'd2048;
      5'd14: r = 27'd1024;
      5'd15: r = 27'd512;
      5'd16: r = 27'd256;
      5'd17: r = 27'd128;
      5'd18: r = 27'd64;
      5'd19: r = 27'd32;
      5'd20: r = 27'd16;
      5'd21: r = 27'd8;
      5'd22: r = 27'd4;
      5'd23: r = 27'd2;
      default: r = 27'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/wfc_ram.sv]
// ----------------------------------------------------------------------------
// wfc_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/wfc_queue.sv]
// ----------------------------------------------------------------------------
// wfc_queue
// short request queue between the front end and the execution back end
// ----------------------------------------------------------------------------
module wfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wfc_pkg::in_item_t push_data,
  output logic              full,
  output logic              pop_valid,
  output wfc_pkg::in_item_t pop_data,
  input  logic              pop
);

  wfc_pkg::in_item_t       mem_r [wfc_pkg::QDEPTH];
  logic [wfc_pkg::QAW-1:0] wp_r, wp_nxt;
  logic [wfc_pkg::QAW-1:0] rp_r, rp_nxt;
  logic [wfc_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full      = (cnt_r == (wfc_pkg::QAW+1)'(wfc_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

[rtl/wfc_front.sv]
// ----------------------------------------------------------------------------
// wfc_front
// input handshake and request classification, drops meaningless requests
// ----------------------------------------------------------------------------
module wfc_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  wfc_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output wfc_pkg::in_item_t q_data
);

  logic keep;

  // func 3 and unknown commands change nothing, so never queue them
  always_comb begin
    keep = 1'b0;
    case (in_data.func)
      wfc_pkg::FUNC_LOAD: keep = 1'b1;
      wfc_pkg::FUNC_TICK: keep = 1'b1;
      wfc_pkg::FUNC_CMD:  keep = (in_data.command <= wfc_pkg::CMD_AUTO);
      default:            keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;
  assign q_data   = in_data;

endmodule

[rtl/wfc_back.sv]
// ----------------------------------------------------------------------------
// wfc_back
// execution back end: waypoint store, goal sequencing, distance check,
// cordic bearing and the phase decision for each control tick
// ----------------------------------------------------------------------------
`include "waypoint_follow_controller_assert.svh"

module wfc_back #(
  parameter int MAX_POINTS   = 64,
  parameter int CREEP_TICKS  = 200,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wfc_pkg::cfg_wr_t   cfg,
  input  logic               q_valid,
  input  wfc_pkg::in_item_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wfc_pkg::out_item_t out_data
);

  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int GW = $clog2(2 * MAX_POINTS);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int CW = 28;
  localparam int ZW = 29;
  localparam int BW = wfc_pkg::ANGW;
  localparam logic [15:0] CREEP_C = 16'(CREEP_TICKS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_MX    = 4'd3;
  localparam logic [3:0] S_MY    = 4'd4;
  localparam logic [3:0] S_MS    = 4'd5;
  localparam logic [3:0] S_MA    = 4'd6;
  localparam logic [3:0] S_MT    = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_CINIT = 4'd9;
  localparam logic [3:0] S_CIT   = 4'd10;
  localparam logic [3:0] S_CFIN  = 4'd11;
  localparam logic [3:0] S_DEC   = 4'd12;

  // configuration
  logic [14:0] cruise_r, turn_r, slow_r, tol_r, trig_r;
  logic [22:0] slow_rad_r, arr_rad_r;
  logic [15:0] dwell_r;

  // control state
  logic [3:0]    st_r, st_nxt;
  logic          top_r, top_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [GW-1:0] goal_r, goal_nxt;
  logic          fin_r, fin_nxt;
  logic          paused_r, paused_nxt;
  logic          auto_r, auto_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] i_r;

  // datapath
  wfc_pkg::out_item_t       out_data_r, out_data_nxt;
  logic signed [23:0]       px_r, py_r;
  logic signed [15:0]       hd_r;
  logic                     blk_r;
  logic signed [24:0]       dx_r, dy_r;
  logic signed [BW-1:0]     yb_r, bias_r;
  logic [48:0]              sqx_r, sqy_r;
  logic [45:0]              sl2_r, ar2_r;
  logic [14:0]              steer_r;
  logic                     in_slow_r, in_arr_r;
  logic signed [CW-1:0]     cx_r, cy_r;
  logic signed [ZW-1:0]     cz_r;
  logic                     zero_r;

  // store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic          pop_tick;
  logic [NW-1:0] load_base;

  wfc_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // goal to slot: out leg direct, return leg mirrored
  logic [GW:0] g_e, n_e, twon2, slot_w;

  always_comb begin
    g_e    = {1'b0, goal_r};
    n_e    = (GW+1)'(cnt_r);
    twon2  = (n_e << 1) - (GW+1)'(2);
    slot_w = '0;
    if (g_e < n_e) begin
      slot_w = g_e;
    end else if (n_e != '0 && g_e <= twon2) begin
      slot_w = twon2 - g_e;
    end
    if (slot_w >= (GW+1)'(MAX_POINTS)) begin
      slot_w = '0;
    end
  end

  assign ram_raddr = slot_w[AW-1:0];

  assign q_pop     = q_valid && st_r == S_IDLE && (!out_valid_r || !out_stall);
  assign pop_tick  = q_pop && q_data.func == wfc_pkg::FUNC_TICK;
  assign load_base = q_data.first_point ? '0 : cnt_r;
  assign ram_we    = q_pop && q_data.func == wfc_pkg::FUNC_LOAD &&
                     load_base < NW'(MAX_POINTS);
  assign ram_waddr = load_base[AW-1:0];
  assign ram_wdata = {q_data.pos_x, q_data.pos_y, q_data.heading};

  // shared multiplier
  logic [24:0] abs_dx, abs_dy, ma, mb;
  logic [49:0] prod;

  assign abs_dx = dx_r[24] ? 25'(-dx_r) : 25'(dx_r);
  assign abs_dy = dy_r[24] ? 25'(-dy_r) : 25'(dy_r);

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      S_MX: begin ma = abs_dx; mb = abs_dx; end
      S_MY: begin ma = abs_dy; mb = abs_dy; end
      S_MS: begin ma = 25'(slow_rad_r); mb = 25'(slow_rad_r); end
      S_MA: begin ma = 25'(arr_rad_r); mb = 25'(arr_rad_r); end
      S_MT: begin ma = 25'({1'b0, turn_r} + 16'd10); mb = wfc_pkg::STEER_RECIP; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  // shift toward zero
  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                  input logic [4:0] s);
    logic [CW-1:0] m;
    m = v[CW-1] ? CW'(-v) : CW'(v);
    m = m >> s;
    return v[CW-1] ? -$signed(m) : $signed(m);
  endfunction

  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] at_z;
  logic [ZW-1:0]        zmag;
  logic [17:0]          zrnd;
  logic signed [BW-1:0] cres;
  logic [49:0]          d2;
  logic signed [24:0]   wx_e, wy_e;

  assign xs   = shr_tz(cx_r, 5'(i_r));
  assign ys   = shr_tz(cy_r, 5'(i_r));
  assign at_z = $signed({2'b00, wfc_pkg::atan_q24(5'(i_r))});
  assign zmag = cz_r[ZW-1] ? ZW'(-cz_r) : ZW'(cz_r);
  assign zrnd = 18'((zmag + ZW'(1024)) >> 11);
  assign d2   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign wx_e = {ram_rdata[63], ram_rdata[63:40]};
  assign wy_e = {ram_rdata[39], ram_rdata[39:16]};

  always_comb begin
    if (zero_r) begin
      cres = (dy_r >= 0) ? wfc_pkg::ANG_HALF_PI : -wfc_pkg::ANG_HALF_PI;
    end else if (cz_r[ZW-1]) begin
      cres = -$signed(BW'(zrnd));
    end else begin
      cres = $signed(BW'(zrnd));
    end
  end

  // decision
  logic [BW-1:0]        abs_b, abs_yb;
  logic signed [15:0]   turn_p, turn_n, steer_p;
  logic [14:0]          speed_sel;
  logic                 leave;
  logic                 e_en;
  logic [14:0]          e_lin;
  logic signed [15:0]   e_ang;
  logic [2:0]           e_ph;

  assign abs_b     = bias_r[BW-1] ? BW'(-bias_r) : BW'(bias_r);
  assign abs_yb    = yb_r[BW-1] ? BW'(-yb_r) : BW'(yb_r);
  assign turn_p    = $signed({1'b0, turn_r});
  assign turn_n    = -turn_p;
  assign steer_p   = $signed({1'b0, steer_r});
  assign speed_sel = in_slow_r ? slow_r : cruise_r;
  assign leave     = fin_r || cnt_r == '0;

  always_comb begin
    st_nxt     = st_r;
    top_nxt    = top_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    goal_nxt   = goal_r;
    fin_nxt    = fin_r;
    paused_nxt = paused_r;
    auto_nxt   = auto_r;
    tick_nxt   = tick_r;
    e_en       = 1'b0;
    e_lin      = '0;
    e_ang      = '0;
    e_ph       = wfc_pkg::PH_IDLE;

    unique case (st_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_data.func)
            wfc_pkg::FUNC_LOAD: begin
              if (q_data.first_point) begin
                goal_nxt  = '0;
                phase_nxt = wfc_pkg::PH_IDLE;
                tick_nxt  = '0;
              end
              fin_nxt = 1'b0;
              cnt_nxt = (load_base < NW'(MAX_POINTS)) ? load_base + 1'b1 : load_base;
            end
            wfc_pkg::FUNC_CMD: begin
              case (q_data.command)
                wfc_pkg::CMD_PAUSE:  paused_nxt = 1'b1;
                wfc_pkg::CMD_RESUME: paused_nxt = 1'b0;
                wfc_pkg::CMD_STOP: begin
                  cnt_nxt   = '0;
                  goal_nxt  = '0;
                  fin_nxt   = 1'b1;
                  phase_nxt = wfc_pkg::PH_IDLE;
                end
                wfc_pkg::CMD_MANUAL: auto_nxt = 1'b0;
                wfc_pkg::CMD_AUTO:   auto_nxt = 1'b1;
                default: ;
              endcase
            end
            default: begin
              top_nxt = 1'b0;
              st_nxt  = S_RD;
            end
          endcase
        end
      end
      S_RD:    st_nxt = S_DIFF;
      S_DIFF:  st_nxt = S_MX;
      S_MX:    st_nxt = S_MY;
      S_MY:    st_nxt = S_MS;
      S_MS:    st_nxt = S_MA;
      S_MA:    st_nxt = S_MT;
      S_MT:    st_nxt = S_CMP;
      S_CMP:   st_nxt = (d2 <= 50'(sl2_r)) ? S_DEC : S_CINIT;
      S_CINIT: st_nxt = (dx_r == '0) ? S_CFIN : S_CIT;
      S_CIT:   st_nxt = (i_r == IW'(CORDIC_STEPS - 1)) ? S_CFIN : S_CIT;
      S_CFIN:  st_nxt = S_DEC;
      S_DEC: begin
        if (!top_r) begin
          unique case (phase_r)
            wfc_pkg::PH_ROTATE: begin
              if (leave) begin
                phase_nxt = wfc_pkg::PH_IDLE;
                top_nxt   = 1'b1;
              end else if (paused_r) begin
                e_en = 1'b1; e_ph = wfc_pkg::PH_ROTATE;
              end else if (abs_b <= BW'(tol_r)) begin
                phase_nxt = wfc_pkg::PH_DRIVE;
                top_nxt   = 1'b1;
              end else begin
                e_en  = 1'b1; e_ph = wfc_pkg::PH_ROTATE;
                e_ang = (bias_r >= 0) ? turn_p : turn_n;
              end
            end
            wfc_pkg::PH_ALIGN: begin
              if (leave) begin
                phase_nxt = wfc_pkg::PH_IDLE;
                top_nxt   = 1'b1;
              end else if (paused_r) begin
                e_en = 1'b1; e_ph = wfc_pkg::PH_ALIGN;
              end else if (abs_yb > BW'(tol_r)) begin
                e_en  = 1'b1; e_ph = wfc_pkg::PH_ALIGN;
                e_ang = (yb_r >= 0) ? turn_p : turn_n;
              end else begin
                tick_nxt = dwell_r;
                e_en = 1'b1; e_ph = wfc_pkg::PH_DWELL;
              end
            end
            wfc_pkg::PH_DWELL: begin
              if (leave) begin
                phase_nxt = wfc_pkg::PH_IDLE;
                top_nxt   = 1'b1;
              end else if (tick_r != '0) begin
                tick_nxt = tick_r - 1'b1;
                e_en = 1'b1; e_ph = wfc_pkg::PH_DWELL;
              end else begin
                top_nxt = 1'b1;
                st_nxt  = S_RD;
                if (g_e + 1'b1 > twon2) begin
                  cnt_nxt   = '0;
                  goal_nxt  = '0;
                  fin_nxt   = 1'b1;
                  phase_nxt = wfc_pkg::PH_IDLE;
                end else begin
                  goal_nxt  = goal_r + 1'b1;
                  phase_nxt = wfc_pkg::PH_DRIVE;
                end
              end
            end
            wfc_pkg::PH_SPIN: begin
              if (leave) begin
                phase_nxt = wfc_pkg::PH_IDLE;
                top_nxt   = 1'b1;
              end else if (!blk_r) begin
                // obstacle gone: first creep tick runs at once
                tick_nxt = 16'd1;
                e_en = 1'b1; e_ph = wfc_pkg::PH_CREEP;
                e_lin = paused_r ? '0 : speed_sel;
              end else begin
                e_en  = 1'b1; e_ph = wfc_pkg::PH_SPIN;
                e_ang = paused_r ? '0 : turn_p;
              end
            end
            wfc_pkg::PH_CREEP: begin
              if (leave) begin
                phase_nxt = wfc_pkg::PH_IDLE;
                top_nxt   = 1'b1;
              end else if (tick_r >= CREEP_C) begin
                phase_nxt = wfc_pkg::PH_DRIVE;
                top_nxt   = 1'b1;
              end else if (paused_r) begin
                tick_nxt = tick_r + 1'b1;
                e_en = 1'b1; e_ph = wfc_pkg::PH_CREEP;
              end else if (blk_r) begin
                phase_nxt = wfc_pkg::PH_DRIVE;
                top_nxt   = 1'b1;
              end else begin
                tick_nxt = tick_r + 1'b1;
                e_en = 1'b1; e_ph = wfc_pkg::PH_CREEP; e_lin = speed_sel;
              end
            end
            default: begin
              if (phase_r > wfc_pkg::PH_CREEP) begin
                phase_nxt = wfc_pkg::PH_IDLE;
              end
              top_nxt = 1'b1;
            end
          endcase
        end else begin
          if (!auto_r) begin
            st_nxt = S_IDLE;
          end else if (paused_r || leave) begin
            e_en = 1'b1; e_ph = wfc_pkg::PH_IDLE;
          end else if (in_arr_r) begin
            if (g_e == n_e - 1'b1) begin
              if (abs_yb > BW'(tol_r)) begin
                e_en  = 1'b1; e_ph = wfc_pkg::PH_ALIGN;
                e_ang = (yb_r >= 0) ? turn_p : turn_n;
              end else begin
                tick_nxt = dwell_r;
                e_en = 1'b1; e_ph = wfc_pkg::PH_DWELL;
              end
            end else if (g_e >= twon2) begin
              cnt_nxt   = '0;
              goal_nxt  = '0;
              fin_nxt   = 1'b1;
              phase_nxt = wfc_pkg::PH_IDLE;
            end else begin
              goal_nxt = goal_r + 1'b1;
              st_nxt   = S_RD;
            end
          end else if (blk_r) begin
            e_en = 1'b1; e_ph = wfc_pkg::PH_SPIN; e_ang = turn_p;
          end else if (abs_b > BW'(trig_r) && abs_b > BW'(tol_r)) begin
            e_en  = 1'b1; e_ph = wfc_pkg::PH_ROTATE;
            e_ang = (bias_r >= 0) ? turn_p : turn_n;
          end else begin
            e_en  = 1'b1; e_ph = wfc_pkg::PH_DRIVE; e_lin = speed_sel;
            e_ang = (bias_r >= 0) ? steer_p : -steer_p;
          end
        end
        if (e_en) begin
          phase_nxt = e_ph;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (e_en) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.linear_speed  = e_lin;
      out_data_nxt.angular_speed = e_ang;
      out_data_nxt.phase         = e_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      top_r       <= 1'b0;
      phase_r     <= wfc_pkg::PH_IDLE;
      cnt_r       <= '0;
      goal_r      <= '0;
      fin_r       <= 1'b1;
      paused_r    <= 1'b0;
      auto_r      <= 1'b1;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
      cruise_r    <= wfc_pkg::RST_CRUISE;
      turn_r      <= wfc_pkg::RST_TURN;
      slow_r      <= wfc_pkg::RST_SLOW;
      slow_rad_r  <= wfc_pkg::RST_SLOW_RAD;
      arr_rad_r   <= wfc_pkg::RST_ARRIVE_RAD;
      tol_r       <= wfc_pkg::RST_ALIGN_TOL;
      trig_r      <= wfc_pkg::RST_ALIGN_TRIG;
      dwell_r     <= wfc_pkg::RST_DWELL;
    end else begin
      st_r        <= st_nxt;
      top_r       <= top_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      goal_r      <= goal_nxt;
      fin_r       <= fin_nxt;
      paused_r    <= paused_nxt;
      auto_r      <= auto_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg.en) begin
        unique case (cfg.index)
          wfc_pkg::CFG_CRUISE:     cruise_r   <= cfg.data[14:0];
          wfc_pkg::CFG_TURN:       turn_r     <= cfg.data[14:0];
          wfc_pkg::CFG_SLOW:       slow_r     <= cfg.data[14:0];
          wfc_pkg::CFG_SLOW_RAD:   slow_rad_r <= cfg.data;
          wfc_pkg::CFG_ARRIVE_RAD: arr_rad_r  <= cfg.data;
          wfc_pkg::CFG_ALIGN_TOL:  tol_r      <= cfg.data[14:0];
          wfc_pkg::CFG_ALIGN_TRIG: trig_r     <= cfg.data[14:0];
          wfc_pkg::CFG_DWELL:      dwell_r    <= cfg.data[15:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop_tick) begin
      px_r  <= q_data.pos_x;
      py_r  <= q_data.pos_y;
      hd_r  <= q_data.heading;
      blk_r <= q_data.blocked;
    end
    case (st_r)
      S_DIFF: begin
        dx_r <= wx_e - {px_r[23], px_r};
        dy_r <= wy_e - {py_r[23], py_r};
        yb_r <= wfc_pkg::wrap_angle(BW'($signed(ram_rdata[15:0])) - BW'(hd_r));
      end
      S_MX: sqx_r <= prod[48:0];
      S_MY: sqy_r <= prod[48:0];
      S_MS: sl2_r <= prod[45:0];
      S_MA: ar2_r <= prod[45:0];
      S_MT: steer_r <= prod[34:20];
      S_CMP: begin
        in_slow_r <= (d2 <= 50'(sl2_r));
        in_arr_r  <= (d2 <= 50'(ar2_r));
        bias_r    <= wfc_pkg::NEAR_BIAS;
      end
      S_CINIT: begin
        i_r    <= '0;
        zero_r <= (dx_r == '0);
        if (dx_r < 0) begin
          cx_r <= -CW'(dx_r);
          cy_r <= -CW'(dy_r);
          cz_r <= (dy_r >= 0) ? wfc_pkg::PI_Q24 : -wfc_pkg::PI_Q24;
        end else begin
          cx_r <= CW'(dx_r);
          cy_r <= CW'(dy_r);
          cz_r <= '0;
        end
      end
      S_CIT: begin
        i_r <= i_r + 1'b1;
        if (cy_r > 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at_z;
        end else if (cy_r < 0) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at_z;
        end
      end
      S_CFIN: bias_r <= wfc_pkg::wrap_angle(cres - BW'(hd_r));
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WFC_ASSERT_IMPL(a_emit_from_decision, $rose(out_valid_r), $past(st_r) == S_DEC)
  `WFC_ASSERT_ALWAYS(a_count_in_range, cnt_r <= NW'(MAX_POINTS))
  `WFC_ASSERT_IMPL(a_finished_empty, fin_r, cnt_r == '0 && goal_r == '0)
  `WFC_ASSERT_NEXT(a_tick_starts_eval, pop_tick, st_r == S_RD)

endmodule

[rtl/waypoint_follow_controller.sv]
// ----------------------------------------------------------------------------
// waypoint_follow_controller
// follows a loaded waypoint path out and back, at most one velocity command per tick
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall  | wfc_pkg::in_item_t
//  out_    | output    | out_valid/out_stall| wfc_pkg::out_item_t
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  loads and commands are handled in the back end's idle state; a tick steps through
//  the shared multiplier sequence and, beyond the slow radius, the iterative cordic,
//  with an extra decision pass when a loop phase hands over to the top-level decision
//  and a new evaluation for each goal passed on arrival; the back end takes no new
//  request until the tick is done.
//  a four-entry queue keeps taking requests meanwhile.
//  rst_n is synchronous; the waypoint store is not cleared.
//  a waiting result sits in the output register; the back end starts no
//  request until it has left.
module waypoint_follow_controller #(
  parameter int MAX_POINTS   = 64,
  parameter int CREEP_TICKS  = 200,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wfc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wfc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);

  wfc_pkg::in_item_t q_in, q_out;
  wfc_pkg::cfg_wr_t  cfg;
  logic              q_push, q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  wfc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  wfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_out),
    .pop       (q_pop)
  );

  wfc_back #(
    .MAX_POINTS   (MAX_POINTS),
    .CREEP_TICKS  (CREEP_TICKS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[bench/wfc_checker.sv]
// ----------------------------------------------------------------------------
// wfc_checker
// watches the request, result and register channels of the waypoint
// follower, predicts the velocity command, if any, for every accepted tick and
// compares each result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module wfc_checker #(
  parameter int MAX_POINTS   = 64,
  parameter int CREEP_TICKS  = 200,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  wfc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  wfc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_Q = 64'sd52707179;
  localparam int     A_PI = 25736;
  localparam int     A_2PI = 51472;
  localparam int     A_HALF = 12868;
  localparam int     NEAR = 82;

  logic [14:0] cruise, turn, slow_spd, tol, trig;
  logic [22:0] slow_rad, arr_rad;
  logic [15:0] dwell;

  int          wx [MAX_POINTS];
  int          wy [MAX_POINTS];
  int          wyaw [MAX_POINTS];
  int unsigned npts, goal, tcount;
  logic [2:0]  ph;
  bit          auto_on, halted, done;

  int                 now_x, now_y, now_h;
  bit                 now_blk;
  wfc_pkg::out_item_t cmd_out;
  wfc_pkg::out_item_t cmd_q [$];

  function automatic longint shr_tz(longint v, int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  function automatic int vec_atan2(longint dy, longint dx);
    longint x, y, z, xs, ys;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0) return (dy >= 0) ? A_HALF : -A_HALF;
    if (dx < 0) begin
      z = (dy >= 0) ? PI_Q : -PI_Q;
      x = -dx;
      y = -dy;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = shr_tz(x, i);
      ys = shr_tz(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(wfc_pkg::atan_q24(i[4:0]));
      end else if (y < 0) begin
        x -= ys; y += xs; z -= longint'(wfc_pkg::atan_q24(i[4:0]));
      end
    end
    // round half away from zero
    if (z >= 0) return int'((z + 1024) >>> 11);
    return -int'(((-z) + 1024) >>> 11);
  endfunction

  function automatic int wrap(int b);
    if (b > A_PI) return b - A_2PI;
    if (b <= -A_PI) return b + A_2PI;
    return b;
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // return leg mirrors the outward one
  function automatic int unsigned slot();
    int unsigned idx;
    if (goal < npts) idx = goal;
    else if (npts > 0 && goal <= 2 * npts - 2) idx = 2 * npts - 2 - goal;
    else idx = 0;
    return (idx < MAX_POINTS) ? idx : 0;
  endfunction

  function automatic bit near_goal(logic [22:0] r);
    longint dx, dy;
    int unsigned k;
    k = slot();
    dx = longint'(wx[k]) - now_x;
    dy = longint'(wy[k]) - now_y;
    return dx * dx + dy * dy <= longint'(r) * longint'(r);
  endfunction

  function automatic int heading_err();
    int unsigned k;
    k = slot();
    if (!near_goal(slow_rad))
      return wrap(vec_atan2(longint'(wy[k]) - now_y, longint'(wx[k]) - now_x) - now_h);
    return NEAR;
  endfunction

  function automatic void emit(int lin, int ang, logic [2:0] p);
    cmd_out.linear_speed  = lin[14:0];
    cmd_out.angular_speed = ang[15:0];
    cmd_out.phase         = p;
    ph = p;
  endfunction

  function automatic void end_path();
    npts = 0;
    goal = 0;
    done = 1;
    ph   = wfc_pkg::PH_IDLE;
  endfunction

  function automatic bit must_leave();
    if (done || npts == 0) begin
      ph = wfc_pkg::PH_IDLE;
      return 1;
    end
    return 0;
  endfunction

  function automatic int turn_signed(int b);
    return (b >= 0) ? int'(turn) : -int'(turn);
  endfunction

  function automatic bit do_rotate();
    int b;
    if (must_leave()) return 0;
    if (halted) begin emit(0, 0, wfc_pkg::PH_ROTATE); return 1; end
    b = heading_err();
    if (iabs(b) <= int'(tol)) begin ph = wfc_pkg::PH_DRIVE; return 0; end
    emit(0, turn_signed(b), wfc_pkg::PH_ROTATE);
    return 1;
  endfunction

  function automatic bit do_align();
    int b;
    if (must_leave()) return 0;
    if (halted) begin emit(0, 0, wfc_pkg::PH_ALIGN); return 1; end
    b = wrap(wyaw[slot()] - now_h);
    if (iabs(b) > int'(tol)) begin
      emit(0, turn_signed(b), wfc_pkg::PH_ALIGN);
      return 1;
    end
    tcount = 32'(dwell);
    emit(0, 0, wfc_pkg::PH_DWELL);
    return 1;
  endfunction

  // dwell ignores pause
  function automatic bit do_dwell();
    if (must_leave()) return 0;
    if (tcount > 0) begin tcount--; emit(0, 0, wfc_pkg::PH_DWELL); return 1; end
    goal++;
    if (goal > 2 * npts - 2) end_path();
    else ph = wfc_pkg::PH_DRIVE;
    return 0;
  endfunction

  function automatic bit do_creep();
    if (must_leave()) return 0;
    if (tcount >= CREEP_TICKS) begin ph = wfc_pkg::PH_DRIVE; return 0; end
    if (halted) begin tcount++; emit(0, 0, wfc_pkg::PH_CREEP); return 1; end
    if (now_blk) begin ph = wfc_pkg::PH_DRIVE; return 0; end
    tcount++;
    emit(near_goal(slow_rad) ? int'(slow_spd) : int'(cruise), 0, wfc_pkg::PH_CREEP);
    return 1;
  endfunction

  function automatic bit do_spin();
    if (must_leave()) return 0;
    if (!now_blk) begin ph = wfc_pkg::PH_CREEP; tcount = 0; return do_creep(); end
    if (halted) begin emit(0, 0, wfc_pkg::PH_SPIN); return 1; end
    emit(0, int'(turn), wfc_pkg::PH_SPIN);
    return 1;
  endfunction

  function automatic bit decide();
    int b, steer;
    while (1) begin
      if (!auto_on) return 0;
      if (halted || done || npts == 0) begin emit(0, 0, wfc_pkg::PH_IDLE); return 1; end
      if (near_goal(arr_rad)) begin
        if (goal == npts - 1) begin ph = wfc_pkg::PH_ALIGN; return do_align(); end
        if (goal >= 2 * npts - 2) end_path();
        else goal++;
        continue;
      end
      if (now_blk) begin ph = wfc_pkg::PH_SPIN; return do_spin(); end
      b = heading_err();
      if (iabs(b) > int'(trig) && iabs(b) > int'(tol)) begin
        ph = wfc_pkg::PH_ROTATE;
        return do_rotate();
      end
      steer = (int'(turn) + 10) / 20;
      emit(near_goal(slow_rad) ? int'(slow_spd) : int'(cruise),
           (b >= 0) ? steer : -steer, wfc_pkg::PH_DRIVE);
      return 1;
    end
    return 0;
  endfunction

  function automatic bit take_request(wfc_pkg::in_item_t it);
    bit r;
    r = 0;
    case (it.func)
      wfc_pkg::FUNC_LOAD: begin
        if (it.first_point) begin
          npts = 0; goal = 0; ph = wfc_pkg::PH_IDLE; tcount = 0;
        end
        done = 0;
        if (npts < MAX_POINTS) begin
          wx[npts]   = int'(it.pos_x);
          wy[npts]   = int'(it.pos_y);
          wyaw[npts] = int'(it.heading);
          npts++;
        end
        return 0;
      end
      wfc_pkg::FUNC_CMD: begin
        case (it.command)
          wfc_pkg::CMD_PAUSE:  halted = 1;
          wfc_pkg::CMD_RESUME: halted = 0;
          wfc_pkg::CMD_STOP:   end_path();
          wfc_pkg::CMD_MANUAL: auto_on = 0;
          wfc_pkg::CMD_AUTO:   auto_on = 1;
          default: ;
        endcase
        return 0;
      end
      wfc_pkg::FUNC_TICK: begin
        now_x   = int'(it.pos_x);
        now_y   = int'(it.pos_y);
        now_h   = int'(it.heading);
        now_blk = it.blocked;
        case (ph)
          wfc_pkg::PH_ROTATE: r = do_rotate();
          wfc_pkg::PH_ALIGN:  r = do_align();
          wfc_pkg::PH_DWELL:  r = do_dwell();
          wfc_pkg::PH_SPIN:   r = do_spin();
          wfc_pkg::PH_CREEP:  r = do_creep();
          default:            if (ph > wfc_pkg::PH_CREEP) ph = wfc_pkg::PH_IDLE;
        endcase
        if (!r) r = decide();
        return r;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    wfc_pkg::out_item_t want;
    if (!rst_n) begin
      cruise = wfc_pkg::RST_CRUISE; turn = wfc_pkg::RST_TURN; slow_spd = wfc_pkg::RST_SLOW;
      slow_rad = wfc_pkg::RST_SLOW_RAD; arr_rad = wfc_pkg::RST_ARRIVE_RAD;
      tol = wfc_pkg::RST_ALIGN_TOL; trig = wfc_pkg::RST_ALIGN_TRIG;
      dwell = wfc_pkg::RST_DWELL;
      npts = 0; goal = 0; tcount = 0; ph = wfc_pkg::PH_IDLE;
      auto_on = 1; halted = 0; done = 1;
      cmd_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wfc_pkg::CFG_CRUISE:     cruise   = cfg_data[14:0];
          wfc_pkg::CFG_TURN:       turn     = cfg_data[14:0];
          wfc_pkg::CFG_SLOW:       slow_spd = cfg_data[14:0];
          wfc_pkg::CFG_SLOW_RAD:   slow_rad = cfg_data;
          wfc_pkg::CFG_ARRIVE_RAD: arr_rad  = cfg_data;
          wfc_pkg::CFG_ALIGN_TOL:  tol      = cfg_data[14:0];
          wfc_pkg::CFG_ALIGN_TRIG: trig     = cfg_data[14:0];
          wfc_pkg::CFG_DWELL:      dwell    = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (take_request(in_data)) cmd_q = {cmd_q, cmd_out};
      end
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          $display("%t unexpected result: expected none, got %h", $realtime, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = cmd_q.pop_front();
          if (out_data.linear_speed !== want.linear_speed ||
              out_data.angular_speed !== want.angular_speed ||
              out_data.phase !== want.phase) begin
            $display(
              "%t mismatch: expected lin %0d ang %0d phase %0d, got lin %0d ang %0d phase %0d",
              $realtime, want.linear_speed, want.angular_speed, want.phase,
              out_data.linear_speed, out_data.angular_speed, out_data.phase);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= cmd_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives waypoint paths, commands and control ticks into the waypoint
// follower under random gaps and stalls, across several register settings
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 1200;
  localparam int LIMIT  = 1500000;

  // item kind that the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  wfc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 0;
  wfc_pkg::out_item_t out_data;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [22:0]        cfg_data = '0;
  int                 fail_count, pending;

  bit          quiet;
  int          stall_left;
  int          cycles;
  int          px [66];
  int          py [66];
  int          pyaw [66];
  int          plen;

  waypoint_follow_controller i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  wfc_checker i_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** waypoint_follow_controller: FAILED **");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send(logic [1:0] f, int x, int y, int h, bit fp, bit blk, logic [2:0] c);
    wfc_pkg::in_item_t it;
    int g;
    it.func = f;
    it.pos_x = x[23:0];
    it.pos_y = y[23:0];
    it.heading = h[15:0];
    it.first_point = fp;
    it.blocked = blk;
    it.command = c;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic tick(int x, int y, int h, bit blk);
    send(wfc_pkg::FUNC_TICK, x, y, h, 1'($urandom_range(0, 1)), blk,
         3'($urandom_range(0, 7)));
  endtask

  task automatic command(logic [2:0] c);
    send(wfc_pkg::FUNC_CMD, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
         1'($urandom_range(0, 1)), c);
  endtask

  task automatic load_path(int n, int span);
    int x, y, h;
    for (int i = 0; i < n; i++) begin
      x = $urandom_range(0, 2 * span) - span;
      y = $urandom_range(0, 2 * span) - span;
      h = $urandom_range(0, 65535) - 32768;
      if (i < 64) begin
        px[i] = x; py[i] = y; pyaw[i] = h;
      end
      send(wfc_pkg::FUNC_LOAD, x, y, h, i == 0, 1'($urandom_range(0, 1)),
           3'($urandom_range(0, 7)));
    end
    plen = (n < 64) ? n : 64;
  endtask

  task automatic cfg_write(logic [2:0] idx, int unsigned v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v[22:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // block idle: every result in, then let trailing arrival passes drain
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_tick();
    int k, x, y, h, r;
    r = $urandom_range(0, 99);
    k = (plen > 0) ? $urandom_range(0, plen - 1) : 0;
    if (plen > 0 && r < 35) begin
      x = px[k]; y = py[k];
    end else if (plen > 0 && r < 55) begin
      x = px[k] + $urandom_range(0, 12000) - 6000;
      y = py[k] + $urandom_range(0, 12000) - 6000;
    end else if (r < 65) begin
      x = $urandom; y = $urandom;
    end else begin
      x = $urandom_range(0, 120000) - 60000;
      y = $urandom_range(0, 120000) - 60000;
    end
    h = ($urandom_range(0, 2) == 0 && plen > 0) ? pyaw[k] + $urandom_range(0, 4000) - 2000
                                                : $urandom_range(0, 65535) - 32768;
    tick(x, y, h, $urandom_range(0, 99) < 20);
  endtask

  task automatic set_regs(int p);
    int unsigned v [8];
    if (p == 1) begin
      v = '{32767, 32767, 32767, 8388607, 8388607, 32767, 32767, 65535};
    end else if (p == 2) begin
      v = '{0, 0, 0, 0, 0, 0, 0, 0};
    end else begin
      v[0] = $urandom_range(0, 32767);
      v[1] = $urandom_range(0, 32767);
      v[2] = $urandom_range(0, 32767);
      v[3] = $urandom_range(2000, 40000);
      v[4] = $urandom_range(500, 8000);
      v[5] = $urandom_range(0, 6000);
      v[6] = $urandom_range(0, 12000);
      v[7] = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) v[$urandom_range(0, 7)] = $urandom_range(0, 8388607);
    end
    cfg_write(wfc_pkg::CFG_CRUISE, v[0]);
    cfg_write(wfc_pkg::CFG_TURN, v[1]);
    cfg_write(wfc_pkg::CFG_SLOW, v[2]);
    cfg_write(wfc_pkg::CFG_SLOW_RAD, v[3]);
    cfg_write(wfc_pkg::CFG_ARRIVE_RAD, v[4]);
    cfg_write(wfc_pkg::CFG_ALIGN_TOL, v[5]);
    cfg_write(wfc_pkg::CFG_ALIGN_TRIG, v[6]);
    cfg_write(wfc_pkg::CFG_DWELL, v[7]);
  endtask

  initial begin
    int r;
    cycles = 0;
    stall_left = 0;
    quiet = 0;
    plen = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty path, ignored items, extreme coordinates, loop phases
    tick(0, 0, 0, 0);
    send(FUNC_UNUSED, $urandom, $urandom, $urandom, 1, 1, 3'($urandom_range(0, 7)));
    for (int c = int'(wfc_pkg::CMD_AUTO) + 1; c < 8; c++) command(3'(c));
    send(wfc_pkg::FUNC_LOAD, 8388607, -8388608, 32767, 1, 0, wfc_pkg::CMD_PAUSE);
    send(wfc_pkg::FUNC_LOAD, -8388608, 8388607, -32768, 0, 1, wfc_pkg::CMD_AUTO);
    tick(8388607, 0, 0, 0);
    tick(-8388608, 8388607, -32768, 1);
    tick(-8388608, 8388607, 32767, 0);
    command(wfc_pkg::CMD_PAUSE);
    tick(0, 0, 0, 0);
    command(wfc_pkg::CMD_MANUAL);
    tick(0, 0, 0, 1);
    command(wfc_pkg::CMD_RESUME);
    command(wfc_pkg::CMD_AUTO);
    command(wfc_pkg::CMD_STOP);
    tick(100, 100, 100, 0);
    send(wfc_pkg::FUNC_LOAD, 0, 0, 0, 1, 0, wfc_pkg::CMD_STOP);
    tick(0, 0, 16000, 0);
    tick(0, 0, 0, 0);
    tick(0, 0, 0, 0);
    command(wfc_pkg::CMD_MANUAL);
    tick(0, 0, 0, 0);
    command(wfc_pkg::CMD_AUTO);

    for (int p = 0; p < 13; p++) begin
      settle();
      if (p > 0) set_regs(p);
      quiet = ($urandom_range(0, 3) == 0);
      if (p == 4) load_path(66, 30000);
      else load_path(($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4),
                     40000);
      if (p == 3) begin
        // long creep that runs out its tick budget
        send(wfc_pkg::FUNC_LOAD, 0, 0, 0, 1, 0, wfc_pkg::CMD_PAUSE);
        plen = 1; px[0] = 0; py[0] = 0; pyaw[0] = 0;
        tick(5000000, 0, 0, 1);
        repeat (205) tick(5000000, $urandom_range(0, 1000), $urandom_range(0, 65535), 0);
      end
      for (int i = 0; i < 52; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6) command(($urandom_range(0, 3) == 0)
                           ? 3'($urandom_range(0, 7))
                           : 3'($urandom_range(wfc_pkg::CMD_PAUSE, wfc_pkg::CMD_RESUME)));
        else if (r < 8) send(FUNC_UNUSED, $urandom, $urandom, $urandom,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             3'($urandom_range(0, 7)));
        else if (r < 10) load_path($urandom_range(1, 3), 40000);
        else random_tick();
      end
      command(wfc_pkg::CMD_RESUME);
      command(wfc_pkg::CMD_AUTO);
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("** waypoint_follow_controller: PASSED **");
    end else begin
      $display("** waypoint_follow_controller: FAILED **");
    end
    $finish;
  end

endmodule
